/* hdl/u2t_pkg.sv */
// ============================================================================
// u2t_pkg
// Types, constants and decode functions for the UTF-8 to token id framer.
// ============================================================================
`timescale 1ns / 1ps

package u2t_pkg;

	localparam int unsigned ID_W   = 21;
	localparam int unsigned SLOT_N = 8;

	localparam logic [7:0]      QMARK    = 8'h3F;
	localparam logic [ID_W-1:0] ID_PAD   = ID_W'(0);
	localparam logic [ID_W-1:0] ID_START = ID_W'(1);
	localparam logic [ID_W-1:0] ID_END   = ID_W'(2);
	localparam logic [ID_W-1:0] CP_CR    = ID_W'(8'h0D);
	localparam logic [ID_W-1:0] CP_LF    = ID_W'(8'h0A);
	localparam logic [ID_W-1:0] CP_TAB   = ID_W'(8'h09);

	localparam logic [2:0] LEN_BAD = 3'd0;
	localparam logic [2:0] LEN_1   = 3'd1;
	localparam logic [2:0] LEN_2   = 3'd2;
	localparam logic [2:0] LEN_3   = 3'd3;
	localparam logic [2:0] LEN_4   = 3'd4;

	// fixed result slots, drained lowest first
	localparam int unsigned SLOT_START = 0;
	localparam int unsigned SLOT_CP_A  = 1;
	localparam int unsigned SLOT_PAD_A = 2;
	localparam int unsigned SLOT_CP_B  = 3;
	localparam int unsigned SLOT_PAD_B = 4;
	localparam int unsigned SLOT_CP_C  = 5;
	localparam int unsigned SLOT_PAD_C = 6;
	localparam int unsigned SLOT_END   = 7;

	typedef logic [ID_W-1:0] cp_t;

	typedef struct packed {
		logic [SLOT_N-1:0] mask;
		cp_t               cp_a;
		cp_t               cp_b;
		cp_t               cp_c;
	} res_list_t;

	typedef struct packed {
		logic [1:0] held_count;
		logic [2:0] needed_length;
		logic       text_started;
	} dec_state_t;

	typedef struct packed {
		res_list_t  list;
		dec_state_t nxt;
		logic       hold_we;
	} dec_out_t;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		priority if (!b[7])                 len = LEN_1;
		else if ((b & 8'hE0) == 8'hC0)      len = LEN_2;
		else if ((b & 8'hF0) == 8'hE0)      len = LEN_3;
		else if ((b & 8'hF8) == 8'hF0)      len = LEN_4;
		else                                len = LEN_BAD;
		return len;
	endfunction

	// a lone byte: ASCII passes as it is, any other byte becomes '?'
	function automatic cp_t single(input logic [7:0] b);
		return b[7] ? ID_W'(QMARK) : ID_W'(b);
	endfunction

	function automatic logic keep(input cp_t cp, input logic filter);
		return !(filter && (cp == CP_CR || cp == CP_LF || cp == CP_TAB));
	endfunction

	// complete sequence: held bytes h0..h(held-1), then b
	function automatic cp_t assemble(input logic [7:0] h0, input logic [7:0] h1,
			input logic [7:0] h2, input logic [7:0] b, input logic [1:0] held);
		cp_t cp;
		unique case (held)
			2'd1:    cp = {10'b0, h0[4:0], b[5:0]};
			2'd2:    cp = {5'b0, h0[3:0], h1[5:0], b[5:0]};
			2'd3:    cp = {h0[2:0], h1[5:0], h2[5:0], b[5:0]};
			default: cp = ID_W'(h0);
		endcase
		return cp;
	endfunction

	function automatic dec_out_t decode(input logic kind, input logic [7:0] b,
			input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] h2,
			input dec_state_t st, input logic filter);
		dec_out_t   d;
		logic       en_a;
		logic       en_b;
		logic       en_c;
		logic [2:0] len;
		logic [2:0] len_h1;
		d      = '0;
		en_a   = 1'b0;
		en_b   = 1'b0;
		en_c   = 1'b0;
		len    = lead_len(b);
		len_h1 = lead_len(h1);
		d.nxt  = st;
		if (kind) begin
			if (st.held_count != 2'd0) begin
				// cut-short sequence: '?' for the lead, then retry the tail
				en_a        = 1'b1;
				d.list.cp_a = ID_W'(QMARK);
				if (st.held_count == 2'd2) begin
					en_b        = 1'b1;
					d.list.cp_b = single(h1);
				end else if (st.held_count == 2'd3) begin
					en_b = 1'b1;
					if (len_h1 == LEN_2) begin
						d.list.cp_b = {10'b0, h1[4:0], h2[5:0]};
					end else begin
						d.list.cp_b = single(h1);
						en_c        = 1'b1;
						d.list.cp_c = single(h2);
					end
				end
			end
			d.nxt = '0;
		end else begin
			d.nxt.text_started = 1'b1;
			if (st.held_count == 2'd0) begin
				if (len == LEN_1) begin
					en_a        = 1'b1;
					d.list.cp_a = ID_W'(b);
				end else if (len == LEN_BAD) begin
					en_a        = 1'b1;
					d.list.cp_a = ID_W'(QMARK);
				end else begin
					d.hold_we           = 1'b1;
					d.nxt.held_count    = 2'd1;
					d.nxt.needed_length = len;
				end
			end else if (({1'b0, st.held_count} + 3'd1) >= st.needed_length
					|| st.held_count == 2'd3) begin
				en_a                = 1'b1;
				d.list.cp_a         = assemble(h0, h1, h2, b, st.held_count);
				d.nxt.held_count    = 2'd0;
				d.nxt.needed_length = 3'd0;
			end else begin
				d.hold_we        = 1'b1;
				d.nxt.held_count = st.held_count + 2'd1;
			end
		end
		en_a = en_a && keep(d.list.cp_a, filter);
		en_b = en_b && keep(d.list.cp_b, filter);
		en_c = en_c && keep(d.list.cp_c, filter);
		d.list.mask[SLOT_START] = !st.text_started;
		d.list.mask[SLOT_CP_A]  = en_a;
		d.list.mask[SLOT_PAD_A] = en_a;
		d.list.mask[SLOT_CP_B]  = en_b;
		d.list.mask[SLOT_PAD_B] = en_b;
		d.list.mask[SLOT_CP_C]  = en_c;
		d.list.mask[SLOT_PAD_C] = en_c;
		d.list.mask[SLOT_END]   = kind;
		return d;
	endfunction

endpackage

/* hdl/utf8_to_token_id_framer.sv */
// ============================================================================
// utf8_to_token_id_framer
// Lenient UTF-8 decoder that frames each text as a stream of token ids.
//
// Usage. Send the bytes of one text on the input channel (kind 0), then one
// end-of-text item (kind 1). The result channel gives id 1 at the start of a
// text, each decoded code point followed by id 0, and id 2 with
// last_of_text set at the end. Both channels move an item when valid is
// high and stall is low. The config channel writes filter_controls (reset
// 1: drop CR, LF and TAB); write it only while the block is idle.
// The first id of an item appears once it has passed the input register,
// then the result slot register. Throughput: one result id per cycle on
// the output port while out_stall is low; the next item moves into the
// result slots as the last id of the current one is taken. An item makes
// two ids for a plain code point, up to seven for an end item that closes
// a cut-short sequence.
// Reset empties both registers, clears the open sequence and the text-start
// flag, and sets the filter. While out_stall is high the current id holds
// and in_stall rises once the input register is full.
// ============================================================================
`timescale 1ns / 1ps

module utf8_to_token_id_framer (
	input  logic                    clk,
	input  logic                    arst_n,
	// input item channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [7:0]              text_byte,
	// result channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [u2t_pkg::ID_W-1:0] token_id,
	output logic                    last_of_text,
	// config write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_filter_controls
);

	import u2t_pkg::*;

	// input register
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	// decoder state
	dec_state_t state_q;
	logic [7:0] held_q [3];
	logic       filter_q;

	// result slots
	res_list_t  list_q;

	dec_out_t          dec;
	logic [SLOT_N-1:0] head;
	logic [SLOT_N-1:0] mask_left;
	logic              out_take;
	logic              last_take;
	logic              load;
	logic              in_take;

	assign cfg_ready = 1'b1;

	assign dec = decode(kind_s1, byte_s1, held_q[0], held_q[1], held_q[2],
		state_q, filter_q);

	// lowest pending slot goes out first
	assign head      = list_q.mask & (~list_q.mask + SLOT_N'(1));
	assign mask_left = list_q.mask & ~head;
	assign out_valid = |list_q.mask;
	assign out_take  = out_valid && !out_stall;
	assign last_take = out_take && (mask_left == '0);

	// the decoded item enters the slots once they are empty or emptying
	assign load     = valid_s1 && (!out_valid || last_take);
	assign in_stall = valid_s1 && !load;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		token_id     = ID_PAD;
		last_of_text = 1'b0;
		priority if (list_q.mask[SLOT_START]) begin
			token_id = ID_START;
		end else if (list_q.mask[SLOT_CP_A]) begin
			token_id = list_q.cp_a;
		end else if (list_q.mask[SLOT_PAD_A]) begin
			token_id = ID_PAD;
		end else if (list_q.mask[SLOT_CP_B]) begin
			token_id = list_q.cp_b;
		end else if (list_q.mask[SLOT_PAD_B]) begin
			token_id = ID_PAD;
		end else if (list_q.mask[SLOT_CP_C]) begin
			token_id = list_q.cp_c;
		end else if (list_q.mask[SLOT_PAD_C]) begin
			token_id = ID_PAD;
		end else if (list_q.mask[SLOT_END]) begin
			token_id     = ID_END;
			last_of_text = 1'b1;
		end else begin
			token_id = ID_PAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
			filter_q <= 1'b1;
			list_q   <= '0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				filter_q <= cfg_filter_controls;
			end
			if (load) begin
				state_q <= dec.nxt;
				list_q  <= dec.list;
			end else if (out_take) begin
				list_q.mask <= mask_left;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= kind;
			byte_s1 <= text_byte;
		end
		if (load && dec.hold_we) begin
			held_q[state_q.held_count] <= byte_s1;
		end
	end

`ifndef SYNTHESIS
	// an open sequence always has room left before it completes
	a_held_below_needed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held_count == 2'd0
		|| state_q.needed_length > {1'b0, state_q.held_count})
		else $error("held count not below needed length");

	// an end item leaves no open sequence and a fresh text
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && kind_s1 |=> state_q.held_count == 2'd0 && !state_q.text_started)
		else $error("end of text did not clear decoder state");

	// the input never stalls with an empty input register
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled while input register empty");

	// a closing id is only shown with all other slots drained
	a_end_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_text |-> head == list_q.mask)
		else $error("end id shown ahead of pending ids");
`endif

endmodule
